>>> rtl/e2q_pkg.sv
// Shared types and constants for the Euler-angle to quaternion pipeline.
package e2q_pkg;

   // Field widths that the interface fixes.
   localparam int IN_WIDTH    = 17;
   localparam int PHASE_WIDTH = 32;
   localparam int TRIG_WIDTH  = 32;

   // Lane order of the three angles inside the pipeline.
   localparam int LANES      = 3;
   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_YAW   = 2;

   // Quaternion component order.
   localparam int COMP_COUNT = 4;
   localparam int COMP_W     = 0;
   localparam int COMP_X     = 1;
   localparam int COMP_Y     = 2;
   localparam int COMP_Z     = 3;

   // The half angle maps 720 degrees onto one phase turn; 720 = 45 * 2^4.
   localparam int DEG_DIV       = 45;
   localparam int DEG_DIV_SHIFT = 4;
   localparam int DEG_ROUND     = 22;

   // Angle magnitude divided by 45 through a reciprocal multiply, exact below 2^17.
   localparam int MAG_WIDTH    = IN_WIDTH;
   localparam int RECIP_WIDTH  = 17;
   localparam logic [RECIP_WIDTH-1:0] RECIP_45 = 17'd93207;
   localparam int RECIP_SHIFT  = 22;
   localparam int QUO_WIDTH    = 11;
   localparam int REM_WIDTH    = 6;

   typedef logic signed [IN_WIDTH-1:0]   angle_type;
   typedef logic signed [TRIG_WIDTH-1:0] trig_type;

   // Cosine and sine of one half angle, both Q30.
   typedef struct packed {
      trig_type cos_val;
      trig_type sin_val;
   } cs_pair_type;

   // CORDIC start value: the inverse gain 0.60725... in Q30.
   localparam trig_type CORDIC_GAIN = 32'sd652032874;

   // atan(2^-i) as a phase, one turn = 2^32.
   localparam trig_type ATAN_PHASE [32] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
      32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
      32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
      32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
      32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051,
      32'sh00000029, 32'sh00000014, 32'sh0000000A, 32'sh00000005,
      32'sh00000003, 32'sh00000001, 32'sh00000001, 32'sh00000000
   };

endpackage

>>> rtl/e2q_trig.sv
// Three-lane pipeline from angle codes to half-angle cosine and sine via CORDIC.
module e2q_trig #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int TRIG_STAGES     = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  e2q_pkg::angle_type   [e2q_pkg::LANES-1:0] in_angle,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output e2q_pkg::cs_pair_type [e2q_pkg::LANES-1:0] out_trig
);
   import e2q_pkg::*;

   localparam int PH_SHIFT  = PHASE_WIDTH - DEG_DIV_SHIFT - ANGLE_FRAC_BITS;
   localparam int ST_CORDIC = 4;
   localparam int ST_OUT    = ST_CORDIC + TRIG_STAGES;
   localparam int NUM_ST    = ST_OUT + 1;

   // Stage valid bits and the ready chain that lets bubbles collapse.
   logic [NUM_ST-1:0] vld_ff;
   logic [NUM_ST-1:0] vld_in;
   logic [NUM_ST-1:0] vld_prev;
   logic [NUM_ST:0]   rdy;

   assign rdy[NUM_ST] = out_ready;
   for (genvar k = 0; k < NUM_ST; k++) begin : g_rdy
      assign rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   assign vld_prev  = {vld_ff[NUM_ST-2:0], in_valid};
   assign vld_in    = (rdy[NUM_ST-1:0] & vld_prev) | (~rdy[NUM_ST-1:0] & vld_ff);
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NUM_ST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Rounded phase fraction for each remainder of the division by 45.
   logic [PHASE_WIDTH-1:0] frac_lut [DEG_DIV];
   for (genvar r = 0; r < DEG_DIV; r++) begin : g_frac
      assign frac_lut[r] = PHASE_WIDTH'(((64'(r) << PH_SHIFT) + 64'(DEG_ROUND)) / 64'(DEG_DIV));
   end

   // Stage 1: sign and magnitude of each angle.
   logic [LANES-1:0][MAG_WIDTH-1:0] mag1_in, mag1_ff;
   logic [LANES-1:0]                neg1_in, neg1_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         neg1_in[l] = in_angle[l][IN_WIDTH-1];
         mag1_in[l] = neg1_in[l] ? MAG_WIDTH'(-in_angle[l]) : MAG_WIDTH'(in_angle[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
      end
   end

   // Stage 2: quotient of the magnitude by 45.
   logic [LANES-1:0][QUO_WIDTH-1:0] quo2_in, quo2_ff;
   logic [LANES-1:0][MAG_WIDTH-1:0] mag2_ff;
   logic [LANES-1:0]                neg2_ff;

   always_comb begin
      logic [MAG_WIDTH+RECIP_WIDTH-1:0] prod;
      for (int l = 0; l < LANES; l++) begin
         prod       = (MAG_WIDTH+RECIP_WIDTH)'(mag1_ff[l]) * (MAG_WIDTH+RECIP_WIDTH)'(RECIP_45);
         quo2_in[l] = prod[RECIP_SHIFT +: QUO_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         quo2_ff <= quo2_in;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: remainder of the magnitude by 45.
   logic [LANES-1:0][REM_WIDTH-1:0] rem3_in, rem3_ff;
   logic [LANES-1:0][QUO_WIDTH-1:0] quo3_ff;
   logic [LANES-1:0]                neg3_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rem3_in[l] = REM_WIDTH'(mag2_ff[l]
                      - MAG_WIDTH'(MAG_WIDTH'(quo2_ff[l]) * MAG_WIDTH'(DEG_DIV)));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         rem3_ff <= rem3_in;
         quo3_ff <= quo2_ff;
         neg3_ff <= neg2_ff;
      end
   end

   // Stage 4: signed phase, folded into the right half plane.
   // Quadrants one and two get 180 degrees added, which toggles the top bit;
   // in every quadrant the folded top bit then equals phase bit 30.
   trig_type [LANES-1:0] z4_in, z4_ff;
   logic     [LANES-1:0] flip4_in, flip4_ff;

   always_comb begin
      logic [QUO_WIDTH+PH_SHIFT-1:0] quo_wide;
      logic [PHASE_WIDTH-1:0]        mag_ph;
      logic [PHASE_WIDTH-1:0]        phase;
      for (int l = 0; l < LANES; l++) begin
         quo_wide    = {quo3_ff[l], {PH_SHIFT{1'b0}}};
         mag_ph      = PHASE_WIDTH'(quo_wide) + frac_lut[rem3_ff[l]];
         phase       = neg3_ff[l] ? -mag_ph : mag_ph;
         flip4_in[l] = phase[PHASE_WIDTH-1] ^ phase[PHASE_WIDTH-2];
         z4_in[l]    = {phase[PHASE_WIDTH-2], phase[PHASE_WIDTH-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         z4_ff    <= z4_in;
         flip4_ff <= flip4_in;
      end
   end

   // CORDIC rotation, one micro-rotation per register stage.
   trig_type [TRIG_STAGES-1:0][LANES-1:0] xc_in, xc_ff;
   trig_type [TRIG_STAGES-1:0][LANES-1:0] yc_in, yc_ff;
   trig_type [TRIG_STAGES-1:0][LANES-1:0] zc_in, zc_ff;
   logic     [TRIG_STAGES-1:0][LANES-1:0] fc_ff;

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cordic
      trig_type [LANES-1:0] xs;
      trig_type [LANES-1:0] ys;
      trig_type [LANES-1:0] zs;
      logic     [LANES-1:0] fs;

      if (i == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               xs[l] = CORDIC_GAIN;
               ys[l] = '0;
            end
         end
         assign zs = z4_ff;
         assign fs = flip4_ff;
      end else begin : g_next
         assign xs = xc_ff[i-1];
         assign ys = yc_ff[i-1];
         assign zs = zc_ff[i-1];
         assign fs = fc_ff[i-1];
      end

      // Rotate toward zero residual phase.
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (!zs[l][TRIG_WIDTH-1]) begin
               xc_in[i][l] = xs[l] - (ys[l] >>> i);
               yc_in[i][l] = ys[l] + (xs[l] >>> i);
               zc_in[i][l] = zs[l] - ATAN_PHASE[i];
            end else begin
               xc_in[i][l] = xs[l] + (ys[l] >>> i);
               yc_in[i][l] = ys[l] - (xs[l] >>> i);
               zc_in[i][l] = zs[l] + ATAN_PHASE[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[ST_CORDIC+i]) begin
            xc_ff[i] <= xc_in[i];
            yc_ff[i] <= yc_in[i];
            zc_ff[i] <= zc_in[i];
            fc_ff[i] <= fs;
         end
      end
   end

   // Output stage: undo the quadrant fold by negating cosine and sine.
   cs_pair_type [LANES-1:0] trig_out_in, trig_out_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (fc_ff[TRIG_STAGES-1][l]) begin
            trig_out_in[l].cos_val = -xc_ff[TRIG_STAGES-1][l];
            trig_out_in[l].sin_val = -yc_ff[TRIG_STAGES-1][l];
         end else begin
            trig_out_in[l].cos_val = xc_ff[TRIG_STAGES-1][l];
            trig_out_in[l].sin_val = yc_ff[TRIG_STAGES-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_OUT]) begin
         trig_out_ff <= trig_out_in;
      end
   end

   assign out_trig = trig_out_ff;

endmodule

>>> rtl/e2q_combine.sv
// Pipeline that forms the four quaternion components from the half-angle trig values.
module e2q_combine #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  e2q_pkg::cs_pair_type [e2q_pkg::LANES-1:0] in_trig,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic signed [OUT_FRAC_BITS+1:0]          quat_w,
   output logic signed [OUT_FRAC_BITS+1:0]          quat_x,
   output logic signed [OUT_FRAC_BITS+1:0]          quat_y,
   output logic signed [OUT_FRAC_BITS+1:0]          quat_z
);
   import e2q_pkg::*;

   localparam int FRAC_Q30   = 30;
   localparam int PROD_WIDTH = 2 * TRIG_WIDTH;
   localparam int PAIR_WIDTH = PROD_WIDTH - FRAC_Q30;
   localparam int TERM_WIDTH = PAIR_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH  = TERM_WIDTH + 1;
   localparam int OUT_WIDTH  = OUT_FRAC_BITS + 2;
   localparam int OUT_SHIFT  = 2 * FRAC_Q30 - OUT_FRAC_BITS;
   localparam int NUM_ST     = 4;

   typedef logic signed [PAIR_WIDTH-1:0] pair_type;
   typedef logic signed [TERM_WIDTH-1:0] term_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;
   typedef logic signed [OUT_WIDTH-1:0]  quat_type;

   localparam logic signed [PROD_WIDTH-1:0] ROUND_Q30 =
      PROD_WIDTH'(1) << (FRAC_Q30 - 1);
   localparam sum_type ROUND_OUT = sum_type'(1) << (OUT_SHIFT - 1);
   localparam sum_type OUT_LIM   = sum_type'(1) << OUT_FRAC_BITS;
   // Components whose second term is subtracted: x and z.
   localparam logic [COMP_COUNT-1:0] COMP_SUB = (COMP_COUNT'(1) << COMP_X)
                                              | (COMP_COUNT'(1) << COMP_Z);

   // Stage valid bits and the ready chain.
   logic [NUM_ST-1:0] vld_ff;
   logic [NUM_ST-1:0] vld_in;
   logic [NUM_ST-1:0] vld_prev;
   logic [NUM_ST:0]   rdy;

   assign rdy[NUM_ST] = out_ready;
   for (genvar k = 0; k < NUM_ST; k++) begin : g_rdy
      assign rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   assign vld_prev  = {vld_ff[NUM_ST-2:0], in_valid};
   assign vld_in    = (rdy[NUM_ST-1:0] & vld_prev) | (~rdy[NUM_ST-1:0] & vld_ff);
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NUM_ST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: yaw-pitch pair products, rounded back to Q30.
   logic signed [PROD_WIDTH-1:0] p_cc, p_ss, p_cs, p_sc;
   pair_type pcc_in, pss_in, pcs_in, psc_in;
   pair_type pcc_ff, pss_ff, pcs_ff, psc_ff;
   trig_type cr_ff, sr_ff;

   assign p_cc = in_trig[LANE_YAW].cos_val * in_trig[LANE_PITCH].cos_val;
   assign p_ss = in_trig[LANE_YAW].sin_val * in_trig[LANE_PITCH].sin_val;
   assign p_cs = in_trig[LANE_YAW].cos_val * in_trig[LANE_PITCH].sin_val;
   assign p_sc = in_trig[LANE_YAW].sin_val * in_trig[LANE_PITCH].cos_val;

   assign pcc_in = PAIR_WIDTH'((p_cc + ROUND_Q30) >>> FRAC_Q30);
   assign pss_in = PAIR_WIDTH'((p_ss + ROUND_Q30) >>> FRAC_Q30);
   assign pcs_in = PAIR_WIDTH'((p_cs + ROUND_Q30) >>> FRAC_Q30);
   assign psc_in = PAIR_WIDTH'((p_sc + ROUND_Q30) >>> FRAC_Q30);

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pcc_ff <= pcc_in;
         pss_ff <= pss_in;
         pcs_ff <= pcs_in;
         psc_ff <= psc_in;
         cr_ff  <= in_trig[LANE_ROLL].cos_val;
         sr_ff  <= in_trig[LANE_ROLL].sin_val;
      end
   end

   // Stage 2: multiply each pair by the roll factor, exact Q60.
   term_type term_a_in [COMP_COUNT];
   term_type term_b_in [COMP_COUNT];
   term_type term_a_ff [COMP_COUNT];
   term_type term_b_ff [COMP_COUNT];

   always_comb begin
      term_a_in[COMP_W] = pcc_ff * cr_ff;
      term_b_in[COMP_W] = pss_ff * sr_ff;
      term_a_in[COMP_X] = pcc_ff * sr_ff;
      term_b_in[COMP_X] = pss_ff * cr_ff;
      term_a_in[COMP_Y] = psc_ff * sr_ff;
      term_b_in[COMP_Y] = pcs_ff * cr_ff;
      term_a_in[COMP_Z] = psc_ff * cr_ff;
      term_b_in[COMP_Z] = pcs_ff * sr_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         term_a_ff <= term_a_in;
         term_b_ff <= term_b_in;
      end
   end

   // Stage 3: sum or difference of the two terms, with half an output LSB added.
   sum_type sum_in [COMP_COUNT];
   sum_type sum_ff [COMP_COUNT];

   always_comb begin
      for (int c = 0; c < COMP_COUNT; c++) begin
         if (COMP_SUB[c]) begin
            sum_in[c] = sum_type'(term_a_ff[c]) - sum_type'(term_b_ff[c]) + ROUND_OUT;
         end else begin
            sum_in[c] = sum_type'(term_a_ff[c]) + sum_type'(term_b_ff[c]) + ROUND_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         sum_ff <= sum_in;
      end
   end

   // Stage 4: drop the fraction and saturate at plus or minus one.
   quat_type quat_in [COMP_COUNT];
   quat_type quat_ff [COMP_COUNT];

   always_comb begin
      sum_type r;
      for (int c = 0; c < COMP_COUNT; c++) begin
         r = sum_ff[c] >>> OUT_SHIFT;
         if (r > OUT_LIM) begin
            quat_in[c] = OUT_WIDTH'(OUT_LIM);
         end else if (r < -OUT_LIM) begin
            quat_in[c] = OUT_WIDTH'(-OUT_LIM);
         end else begin
            quat_in[c] = OUT_WIDTH'(r);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         quat_ff <= quat_in;
      end
   end

   assign quat_w = quat_ff[COMP_W];
   assign quat_x = quat_ff[COMP_X];
   assign quat_y = quat_ff[COMP_Y];
   assign quat_z = quat_ff[COMP_Z];

endmodule

>>> rtl/euler_to_quaternion.sv
// Top level: roll, pitch and yaw to a Z-Y-X attitude quaternion.
//
// A request carries roll, pitch and yaw as signed codes in units of
// 2^-ANGLE_FRAC_BITS degree; any code is taken and the half angles wrap
// every turn, so the angles wrap every 720 degrees. A response carries the
// quaternion (w, x, y, z) in signed Q1.OUT_FRAC_BITS, saturated at plus or
// minus one. Both channels use a valid/ready handshake.
// From request to response, the sign and magnitude, quotient, remainder
// and folded phase stages turn each angle into a folded phase, the CORDIC
// has one register stage per micro-rotation, an output stage undoes the
// fold, and the combine stages form the products, sums and saturation.
// Throughput is one request per cycle unless the pipeline is full; every
// stage holds its own valid bit. When the receiver stalls, stages keep
// filling until the pipeline is full, so up to TRIG_STAGES + 9 requests
// are held without loss; empty stages are closed up as data moves on.
// Reset clears all valid bits; the data registers are not reset.
module euler_to_quaternion #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int OUT_FRAC_BITS   = 14,
   parameter int TRIG_STAGES     = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  e2q_pkg::angle_type              req_roll_angle,
   input  e2q_pkg::angle_type              req_pitch_angle,
   input  e2q_pkg::angle_type              req_yaw_angle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_quat_w,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_quat_x,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_quat_y,
   output logic signed [OUT_FRAC_BITS+1:0] rsp_quat_z
);
   import e2q_pkg::*;

   // Angles gathered into lanes for the trig pipeline.
   angle_type   [LANES-1:0] req_angle;
   cs_pair_type [LANES-1:0] trig;
   logic                    trig_valid;
   logic                    trig_ready;

   assign req_angle[LANE_ROLL]  = req_roll_angle;
   assign req_angle[LANE_PITCH] = req_pitch_angle;
   assign req_angle[LANE_YAW]   = req_yaw_angle;

   e2q_trig #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .TRIG_STAGES     (TRIG_STAGES)
   ) u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_angle  (req_angle),
      .out_valid (trig_valid),
      .out_ready (trig_ready),
      .out_trig  (trig)
   );

   e2q_combine #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .in_ready  (trig_ready),
      .in_trig   (trig),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .quat_w    (rsp_quat_w),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z)
   );

endmodule

>>> verif/tb.sv
// Self-checking testbench for the Euler-angle to attitude-quaternion pipeline.
`timescale 1ns / 1ps

module tb;
   import e2q_pkg::*;

   localparam int ANGLE_FRAC_BITS = 7;
   localparam int OUT_FRAC_BITS   = 14;
   localparam int TRIG_STAGES     = 16;
   localparam int CLOCK_PERIOD    = 10;
   localparam int PIPE_LATENCY    = TRIG_STAGES + 9;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PRESSURE_HOLD   = 300;
   localparam int DEG             = 1 << ANGLE_FRAC_BITS;

   // Fixed-point constants of the CORDIC: start value and per-stage rotation.
   localparam longint CORDIC_START = 652032874;
   localparam longint ARCTAN_PHASE_LUT [32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
      'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
      'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
      'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
      'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005,
      'h00000003, 'h00000001, 'h00000001, 'h00000000
   };

   typedef logic signed [OUT_FRAC_BITS+1:0] quat_comp_type;

   typedef struct packed {
      quat_comp_type w;
      quat_comp_type x;
      quat_comp_type y;
      quat_comp_type z;
   } quat_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   angle_type     req_roll_angle = '0;
   angle_type     req_pitch_angle = '0;
   angle_type     req_yaw_angle = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   quat_comp_type rsp_quat_w;
   quat_comp_type rsp_quat_x;
   quat_comp_type rsp_quat_y;
   quat_comp_type rsp_quat_z;

   quat_type expected_quats[$];
   int       error_count = 0;
   int       requests_sent = 0;
   int       responses_checked = 0;
   int       input_stall_cycles = 0;
   int       idle_cycles = 0;
   bit       gap_enable = 1'b1;
   bit       stall_enable = 1'b1;
   int       pending_hold = 0;

   euler_to_quaternion #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .OUT_FRAC_BITS  (OUT_FRAC_BITS),
      .TRIG_STAGES    (TRIG_STAGES)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_roll_angle (req_roll_angle),
      .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle  (req_yaw_angle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_quat_w     (rsp_quat_w),
      .rsp_quat_x     (rsp_quat_x),
      .rsp_quat_y     (rsp_quat_y),
      .rsp_quat_z     (rsp_quat_z)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Cosine and sine (Q30) of half the angle code, through a folded CORDIC.
   function automatic void half_angle_cos_sin(input angle_type code,
                                              output longint cos_q30,
                                              output longint sin_q30);
      longint      num;
      longint      mag;
      longint      quo;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      logic [31:0] phase;
      logic        fold;
      num = longint'(code) * (longint'(1) << (32 - ANGLE_FRAC_BITS));
      mag = (num < 0) ? -num : num;
      quo = (mag + 360) / 720;
      phase = 32'((num < 0) ? -quo : quo);
      // Phases in the left half-plane are turned by half a turn first.
      fold = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
      if (fold) begin
         phase = phase + 32'h8000_0000;
      end
      z = longint'(signed'(phase));
      x = CORDIC_START;
      y = 0;
      for (int i = 0; i < TRIG_STAGES && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_PHASE_LUT[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_PHASE_LUT[i];
         end
      end
      cos_q30 = fold ? -x : x;
      sin_q30 = fold ? -y : y;
   endfunction

   // Product of three Q30 values in Q60; the first pair is rounded back to Q30.
   function automatic longint triple_product(input longint a, input longint b,
                                             input longint c);
      longint pair;
      pair = (a * b + (longint'(1) << 29)) >>> 30;
      return pair * c;
   endfunction

   // Q60 sum rounded to the output format and clamped at plus or minus one.
   function automatic quat_comp_type round_component(input longint v60);
      longint r;
      longint lim;
      r = (v60 + (longint'(1) << (59 - OUT_FRAC_BITS))) >>> (60 - OUT_FRAC_BITS);
      lim = longint'(1) << OUT_FRAC_BITS;
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return quat_comp_type'(r);
   endfunction

   function automatic quat_type predict_quaternion(input angle_type roll,
                                                   input angle_type pitch,
                                                   input angle_type yaw);
      longint   cr, sr, cp, sp, cy, sy;
      quat_type q;
      half_angle_cos_sin(roll, cr, sr);
      half_angle_cos_sin(pitch, cp, sp);
      half_angle_cos_sin(yaw, cy, sy);
      q.w = round_component(triple_product(cy, cp, cr) + triple_product(sy, sp, sr));
      q.x = round_component(triple_product(cy, cp, sr) - triple_product(sy, sp, cr));
      q.y = round_component(triple_product(sy, cp, sr) + triple_product(cy, sp, cr));
      q.z = round_component(triple_product(sy, cp, cr) - triple_product(cy, sp, sr));
      return q;
   endfunction

   // Sender idle time before a request: mostly none or short, sometimes long.
   function automatic int sender_gap();
      int pick;
      if (!gap_enable) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Mostly within +-360 degrees, some near right angles, some raw 17-bit codes.
   function automatic angle_type random_angle();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         return angle_type'(int'($urandom_range(0, 92160)) - 46080);
      end else if (pick < 90) begin
         return angle_type'((int'($urandom_range(0, 8)) - 4) * 90 * DEG
                            + int'($urandom_range(0, 6)) - 3);
      end
      return angle_type'(int'($urandom_range(0, 131071)) - 65536);
   endfunction

   // Offers one request and returns at the edge where it is accepted.
   // Valid stays high on return so a following request can go back to back.
   task automatic send_angles(input angle_type roll, input angle_type pitch,
                              input angle_type yaw);
      int       gap;
      quat_type predicted;
      gap = sender_gap();
      predicted = predict_quaternion(roll, pitch, yaw);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_roll_angle  <= roll;
      req_pitch_angle <= pitch;
      req_yaw_angle   <= yaw;
      do @(posedge clock); while (!req_ready);
      expected_quats.push_back(predicted);
      requests_sent++;
   endtask

   // Directed requests are written as plain integers and narrowed to angle codes here.
   task automatic send_codes(input int roll, input int pitch, input int yaw);
      send_angles(angle_type'(roll), angle_type'(pitch), angle_type'(yaw));
   endtask

   task automatic check_component(input string name, input quat_comp_type want,
                                  input quat_comp_type got);
      if (want !== got) begin
         $display("%0t: quat_%s mismatch: expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Every accepted response is compared with the oldest outstanding prediction.
   always @(posedge clock) begin
      quat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_quats.size() == 0) begin
            $display("%0t: unexpected response (%0d, %0d, %0d, %0d)", $time,
                     rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
            error_count++;
         end else begin
            want = expected_quats.pop_front();
            check_component("w", want.w, rsp_quat_w);
            check_component("x", want.x, rsp_quat_x);
            check_component("y", want.y, rsp_quat_y);
            check_component("z", want.z, rsp_quat_z);
            responses_checked++;
         end
      end
   end

   // Receiver: random ready and stall stretches, plus a long hold on request.
   initial begin
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (pending_hold > 0) begin
            hold = pending_hold;
            pending_hold = 0;
            rsp_ready <= 1'b0;
         end else if (stall_enable && $urandom_range(0, 99) < 25) begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 4);
            rsp_ready <= 1'b0;
         end else begin
            hold = $urandom_range(1, 12);
            rsp_ready <= 1'b1;
         end
         repeat (hold) @(posedge clock);
      end
   end

   // Count cycles in which the block holds off the sender.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready) begin
         input_stall_cycles++;
      end
   end

   // Watchdog: too long without any handshake on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Zero, right angles, half and full turns, gimbal lock, quadrant edges and
   // the raw extremes of the 17-bit code.
   task automatic test_directed_angles();
      send_codes(0, 0, 0);
      send_codes(90 * DEG, 0, 0);
      send_codes(0, 90 * DEG, 0);
      send_codes(0, 0, 90 * DEG);
      send_codes(-90 * DEG, -90 * DEG, -90 * DEG);
      send_codes(180 * DEG, 180 * DEG, 180 * DEG);
      send_codes(-180 * DEG, 0, 180 * DEG);
      send_codes(360 * DEG, -360 * DEG, 360 * DEG);
      send_codes(-360 * DEG, 360 * DEG, -360 * DEG);
      send_codes(0, 90 * DEG, 45 * DEG);
      send_codes(30 * DEG, -90 * DEG, -60 * DEG);
      send_codes(270 * DEG, -270 * DEG, 135 * DEG);
      send_codes(65535, -65536, 65535);
      send_codes(-65536, 65535, -65536);
      send_codes(1, -1, 1);
      send_codes(-1, 1, -1);
      send_codes(45 * DEG, 45 * DEG, 45 * DEG);
      send_codes(-45 * DEG, 120 * DEG, -150 * DEG);
      send_codes(180 * DEG - 1, 180 * DEG + 1, -180 * DEG - 1);
      send_codes(10 * DEG, 20 * DEG, 30 * DEG);
   endtask

   task automatic test_random_angles(input int count);
      gap_enable = 1'b1;
      stall_enable = 1'b1;
      repeat (count) send_angles(random_angle(), random_angle(), random_angle());
   endtask

   // Full rate on both sides.
   task automatic test_back_to_back(input int count);
      gap_enable = 1'b0;
      stall_enable = 1'b0;
      repeat (count) send_angles(random_angle(), random_angle(), random_angle());
   endtask

   // The receiver stops for a long time while requests keep coming, so the
   // pipeline fills and must hold off the sender without losing anything.
   task automatic test_input_backpressure(input int count);
      gap_enable = 1'b0;
      stall_enable = 1'b0;
      pending_hold = PRESSURE_HOLD;
      repeat (count) send_angles(random_angle(), random_angle(), random_angle());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_angles();
      test_random_angles(150);
      test_back_to_back(40);
      test_input_backpressure(60);
      test_random_angles(180);

      req_valid <= 1'b0;
      stall_enable = 1'b1;
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);

      $display("Run covered %0d angle requests and %0d checked quaternions,",
               requests_sent, responses_checked);
      $display("with %0d cycles of input back-pressure and %0d mismatches.",
               input_stall_cycles, error_count);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/e2q_pkg.sv
rtl/e2q_trig.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
verif/tb.sv
